// File: src/vdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vdp_pkg;

   localparam int RATE_BITS     = 17;
   localparam int FLOOR_BITS    = 16;
   localparam int MAG_BITS      = 26;
   localparam int LIFE_BITS     = 31;
   localparam int AGE_BITS      = 32;
   localparam int SUM_BITS      = 52;
   localparam int MAG_SQ_BITS   = 2 * MAG_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 31;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_RATE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR_VALUE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_MAGNITUDE = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LIFETIME  = 2'd3;

   localparam logic [RATE_BITS-1:0]  DECAY_RATE_RESET    = 17'd62259;
   localparam logic [FLOOR_BITS-1:0] FLOOR_VALUE_RESET   = 16'd1;
   localparam logic [MAG_BITS-1:0]   MIN_MAGNITUDE_RESET = 26'd6554;
   localparam logic [LIFE_BITS-1:0]  MAX_LIFETIME_RESET  = 31'd60000;

   typedef struct packed {
      logic [RATE_BITS-1:0]  rate_q16;
      logic [FLOOR_BITS-1:0] floor_value;
      logic [MAG_BITS-1:0]   mag_limit;
      logic [LIFE_BITS-1:0]  max_lifetime;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic dec;
      logic sqr;
      logic acc;
   } cmd_type;

endpackage

`default_nettype wire

// File: src/vdp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vdp_req_if #(
   parameter int VALUE_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] comp_value;
   logic [vdp_pkg::AGE_BITS-1:0] age_ms;
   logic                         last_comp;

   modport source (output valid, output comp_value, output age_ms, output last_comp,
                   input ready);
   modport sink (input valid, input comp_value, input age_ms, input last_comp,
                 output ready);
endinterface

`default_nettype wire

// File: src/vdp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vdp_rsp_if #(
   parameter int VALUE_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-2:0] decayed_value;
   logic                  vector_done;
   logic                  keep;
   logic                  too_weak;
   logic                  expired;

   modport source (output valid, output decayed_value, output vector_done, output keep,
                   output too_weak, output expired, input ready);
   modport sink (input valid, input decayed_value, input vector_done, input keep,
                 input too_weak, input expired, output ready);
endinterface

`default_nettype wire

// File: src/vdp_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module vdp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [vdp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [vdp_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   output vdp_pkg::cfg_type                        cfg
);

   vdp_pkg::cfg_type cfg_ff;
   vdp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            vdp_pkg::CSR_DECAY_RATE: begin
               cfg_in.rate_q16 = csr_wr_data[vdp_pkg::RATE_BITS-1:0];
            end
            vdp_pkg::CSR_FLOOR_VALUE: begin
               cfg_in.floor_value = csr_wr_data[vdp_pkg::FLOOR_BITS-1:0];
            end
            vdp_pkg::CSR_MIN_MAGNITUDE: begin
               cfg_in.mag_limit = csr_wr_data[vdp_pkg::MAG_BITS-1:0];
            end
            vdp_pkg::CSR_MAX_LIFETIME: begin
               cfg_in.max_lifetime = csr_wr_data[vdp_pkg::LIFE_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_q16     <= vdp_pkg::DECAY_RATE_RESET;
         cfg_ff.floor_value  <= vdp_pkg::FLOOR_VALUE_RESET;
         cfg_ff.mag_limit    <= vdp_pkg::MIN_MAGNITUDE_RESET;
         cfg_ff.max_lifetime <= vdp_pkg::MAX_LIFETIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: src/vdp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vdp_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output vdp_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DEC,
      ST_SQR,
      ST_ACC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = req_valid && req_ready;
      cmd.mul  = (state_ff == ST_MUL);
      cmd.dec  = (state_ff == ST_DEC);
      cmd.sqr  = (state_ff == ST_SQR);
      cmd.acc  = (state_ff == ST_ACC) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            state_in = ST_SQR;
         end
         ST_SQR: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // hold until the output slot frees
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_MUL)
      else $error("accepted request did not start the multiply step");

   a_acc_posts: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("accumulate step did not post a response");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) && !slot_free |=> state_ff == ST_ACC)
      else $error("accumulate step left while the output slot was full");

endmodule

`default_nettype wire

// File: src/vdp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module vdp_datapath #(
   parameter int FRAC_BITS  = 16,
   parameter int VALUE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vdp_pkg::cmd_type              cmd,
   input  wire vdp_pkg::cfg_type              cfg,
   input  wire logic signed [VALUE_BITS-1:0]  req_comp_value,
   input  wire logic [vdp_pkg::AGE_BITS-1:0]  req_age_ms,
   input  wire logic                          req_last_comp,
   output logic [VALUE_BITS-2:0]              rsp_decayed_value,
   output logic                               rsp_vector_done,
   output logic                               rsp_keep,
   output logic                               rsp_too_weak,
   output logic                               rsp_expired
);

   localparam int POS_BITS  = VALUE_BITS - 1;
   localparam int DW        = (POS_BITS > vdp_pkg::FLOOR_BITS) ? POS_BITS : vdp_pkg::FLOOR_BITS;
   localparam int PROD_BITS = POS_BITS + vdp_pkg::RATE_BITS;
   localparam int SQ_BITS   = 2 * DW;
   localparam int ACC_BITS  = ((vdp_pkg::SUM_BITS > SQ_BITS) ? vdp_pkg::SUM_BITS : SQ_BITS) + 1;
   localparam int CMP_BITS  = vdp_pkg::SUM_BITS + 2;

   localparam logic [PROD_BITS-1:0] POS_MAX = PROD_BITS'((64'd1 << POS_BITS) - 64'd1);
   localparam logic [ACC_BITS-1:0]  SUM_MAX = ACC_BITS'({vdp_pkg::SUM_BITS{1'b1}});

   logic signed [VALUE_BITS-1:0]      comp_ff;
   logic [vdp_pkg::AGE_BITS-1:0]      age_ff;
   logic                              last_ff;
   logic [PROD_BITS-1:0]              prod_ff;
   logic [PROD_BITS-1:0]              prod_in;
   logic [vdp_pkg::MAG_SQ_BITS-1:0]   mag_sq_ff;
   logic [vdp_pkg::MAG_SQ_BITS-1:0]   mag_sq_in;
   logic [DW-1:0]                     d_ff;
   logic [DW-1:0]                     d_in;
   logic [SQ_BITS-1:0]                sq_ff;
   logic [SQ_BITS-1:0]                sq_in;
   logic [vdp_pkg::SUM_BITS-1:0]      sum_ff;
   logic [vdp_pkg::SUM_BITS-1:0]      sum_in;
   logic [POS_BITS-1:0]               value_ff;
   logic                              done_ff;
   logic                              keep_ff;
   logic                              weak_ff;
   logic                              expired_ff;

   logic [POS_BITS-1:0]               mag;
   logic [PROD_BITS-1:0]              shifted;
   logic [DW-1:0]                     clip;
   logic [DW-1:0]                     floor_ext;
   logic [ACC_BITS-1:0]               sum_ext;
   logic [vdp_pkg::SUM_BITS-1:0]      sum_sat;
   logic                              norm_ok;
   logic                              fresh;

   // drop negative components to zero so the product lands on the floor
   assign mag       = comp_ff[VALUE_BITS-1] ? '0 : comp_ff[POS_BITS-1:0];
   assign prod_in   = PROD_BITS'(mag) * PROD_BITS'(cfg.rate_q16);
   assign mag_sq_in = vdp_pkg::MAG_SQ_BITS'(cfg.mag_limit) *
                      vdp_pkg::MAG_SQ_BITS'(cfg.mag_limit);

   assign shifted   = prod_ff >> FRAC_BITS;
   assign clip      = (shifted > POS_MAX) ? DW'(POS_MAX) : DW'(shifted);
   assign floor_ext = DW'(cfg.floor_value);
   assign d_in      = (clip < floor_ext) ? floor_ext : clip;

   assign sq_in     = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);

   assign sum_ext   = ACC_BITS'(sum_ff) + ACC_BITS'(sq_ff);
   assign sum_sat   = (sum_ext > SUM_MAX) ? {vdp_pkg::SUM_BITS{1'b1}}
                                          : sum_ext[vdp_pkg::SUM_BITS-1:0];
   assign norm_ok   = {sum_sat, 2'b00} > CMP_BITS'(mag_sq_ff);
   assign fresh     = age_ff < {cfg.max_lifetime, 1'b0};
   assign sum_in    = last_ff ? '0 : sum_sat;

   assign rsp_decayed_value = value_ff;
   assign rsp_vector_done   = done_ff;
   assign rsp_keep          = keep_ff;
   assign rsp_too_weak      = weak_ff;
   assign rsp_expired       = expired_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         comp_ff <= req_comp_value;
         age_ff  <= req_age_ms;
         last_ff <= req_last_comp;
      end
      if (cmd.mul) begin
         prod_ff   <= prod_in;
         mag_sq_ff <= mag_sq_in;
      end
      if (cmd.dec) begin
         d_ff <= d_in;
      end
      if (cmd.sqr) begin
         sq_ff <= sq_in;
      end
      if (cmd.acc) begin
         value_ff   <= d_ff[POS_BITS-1:0];
         done_ff    <= last_ff;
         keep_ff    <= last_ff && norm_ok && fresh;
         weak_ff    <= last_ff && !norm_ok;
         expired_ff <= last_ff && !fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff <= sum_in;
      end
   end

   a_floor_held: assert property (@(posedge clock) disable iff (reset)
      cmd.dec |=> d_ff >= DW'($past(cfg.floor_value)))
      else $error("decayed value fell below the floor");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.acc && last_ff |=> sum_ff == '0)
      else $error("accumulator not cleared after last component");

   a_done_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> !rsp_vector_done || (rsp_keep != (rsp_too_weak || rsp_expired)))
      else $error("keep disagrees with weak and expired flags");

endmodule

`default_nettype wire

// File: src/vector_decay_prune.sv
`timescale 1ns / 1ps
`default_nettype none

// Port group  Direction  Handshake                Payload
// req_chan    in         valid/ready              comp_value, age_ms, last_comp
// rsp_chan    out        valid/ready              decayed_value, vector_done, keep,
//                                                 too_weak, expired
// csr_*       in         csr_wr_en, no backpress  csr_index, csr_wr_data
//
// Each request passes in order through accept, decay multiply, saturate and floor, square,
// accumulate; the single sequencer in vdp_ctrl walks these steps for one request.
// A finished response sits in the output register while the next request is taken.
// Accumulate stalls while an earlier response is still untaken.
// Reset loads register defaults and clears the accumulator.

module vector_decay_prune #(
   parameter int FRAC_BITS  = 16,
   parameter int VALUE_BITS = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   vdp_req_if.sink                                 req_chan,
   vdp_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [vdp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [vdp_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);

   vdp_pkg::cfg_type cfg;
   vdp_pkg::cmd_type cmd;

   vdp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   vdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   vdp_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_comp_value    (req_chan.comp_value),
      .req_age_ms        (req_chan.age_ms),
      .req_last_comp     (req_chan.last_comp),
      .rsp_decayed_value (rsp_chan.decayed_value),
      .rsp_vector_done   (rsp_chan.vector_done),
      .rsp_keep          (rsp_chan.keep),
      .rsp_too_weak      (rsp_chan.too_weak),
      .rsp_expired       (rsp_chan.expired)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int FRAC_BITS    = 16;
   localparam int VALUE_BITS   = 24;
   localparam int DRAIN_CYCLES = 12;
   localparam int PRINT_LIMIT  = 40;
   localparam int IDX_W        = vdp_pkg::CSR_IDX_BITS;
   localparam int DATA_W       = vdp_pkg::CSR_DATA_BITS;
   localparam int AGE_W        = vdp_pkg::AGE_BITS;

   localparam bit [63:0] POS_MAX = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
   localparam bit [63:0] SUM_MAX = (64'd1 << vdp_pkg::SUM_BITS) - 64'd1;

   localparam logic [VALUE_BITS-1:0] COMP_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] COMP_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] COMP_NEG1 = {VALUE_BITS{1'b1}};

   typedef struct packed {
      logic [VALUE_BITS-2:0] decayed_value;
      logic                  vector_done;
      logic                  keep;
      logic                  too_weak;
      logic                  expired;
   } decay_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wr_data;

   vdp_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   vdp_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_chan ();

   vector_decay_prune #(
      .FRAC_BITS (FRAC_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   logic [vdp_pkg::RATE_BITS-1:0]  cfg_rate  = vdp_pkg::DECAY_RATE_RESET;
   logic [vdp_pkg::FLOOR_BITS-1:0] cfg_floor = vdp_pkg::FLOOR_VALUE_RESET;
   logic [vdp_pkg::MAG_BITS-1:0]   cfg_mag   = vdp_pkg::MIN_MAGNITUDE_RESET;
   logic [vdp_pkg::LIFE_BITS-1:0]  cfg_life  = vdp_pkg::MAX_LIFETIME_RESET;
   bit [63:0]                      norm_acc  = 64'd0;

   decay_result_type expected_decays[$];
   int error_count = 0;
   bit gaps_on = 1'b1;
   int rsp_hold;

   always #2 clock = ~clock;

   function automatic decay_result_type decay_component(logic [VALUE_BITS-1:0] comp,
                                                        logic [AGE_W-1:0] age, logic last);
      decay_result_type res;
      bit [63:0] prod;
      bit [63:0] dval;
      bit [63:0] sq;
      bit norm_ok;
      bit fresh;
      prod = 64'd0;
      if (!comp[VALUE_BITS-1] && comp != '0) begin
         prod = (64'(comp) * 64'(cfg_rate)) >> FRAC_BITS;
         if (prod > POS_MAX) prod = POS_MAX;
      end
      dval = (prod < 64'(cfg_floor)) ? 64'(cfg_floor) : prod;
      sq = dval * dval;
      if (sq >= SUM_MAX - norm_acc) norm_acc = SUM_MAX;
      else norm_acc = norm_acc + sq;
      res.decayed_value = dval[VALUE_BITS-2:0];
      res.vector_done   = last;
      res.keep          = 1'b0;
      res.too_weak      = 1'b0;
      res.expired       = 1'b0;
      if (last) begin
         norm_ok = (norm_acc << 2) > (64'(cfg_mag) * 64'(cfg_mag));
         fresh   = 64'(age) < (64'(cfg_life) << 1);
         res.keep     = norm_ok && fresh;
         res.too_weak = !norm_ok;
         res.expired  = !fresh;
         norm_acc = 64'd0;
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // fill the bits above the register width with noise; the block must drop them
   function automatic logic [DATA_W-1:0] pad_upper(logic [DATA_W-1:0] value, int width);
      logic [DATA_W-1:0] mask;
      mask = (width >= DATA_W) ? '1 : ((DATA_W'(1) << width) - 1'b1);
      return (value & mask) | (DATA_W'($urandom) & ~mask);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns %s: got %0h, want %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         vdp_pkg::CSR_DECAY_RATE:    cfg_rate  = data[vdp_pkg::RATE_BITS-1:0];
         vdp_pkg::CSR_FLOOR_VALUE:   cfg_floor = data[vdp_pkg::FLOOR_BITS-1:0];
         vdp_pkg::CSR_MIN_MAGNITUDE: cfg_mag   = data[vdp_pkg::MAG_BITS-1:0];
         vdp_pkg::CSR_MAX_LIFETIME:  cfg_life  = data[vdp_pkg::LIFE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(logic [DATA_W-1:0] rate, logic [DATA_W-1:0] floor,
                              logic [DATA_W-1:0] mag, logic [DATA_W-1:0] life);
      write_csr(vdp_pkg::CSR_DECAY_RATE,    pad_upper(rate,  vdp_pkg::RATE_BITS));
      write_csr(vdp_pkg::CSR_FLOOR_VALUE,   pad_upper(floor, vdp_pkg::FLOOR_BITS));
      write_csr(vdp_pkg::CSR_MIN_MAGNITUDE, pad_upper(mag,   vdp_pkg::MAG_BITS));
      write_csr(vdp_pkg::CSR_MAX_LIFETIME,  pad_upper(life,  vdp_pkg::LIFE_BITS));
   endtask

   task automatic send_component(logic [VALUE_BITS-1:0] comp, logic [AGE_W-1:0] age,
                                 logic last);
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.comp_value <= comp;
      req_chan.age_ms     <= age;
      req_chan.last_comp  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_decays.insert(expected_decays.size(), decay_component(comp, age, last));
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, then hold until every response is back and the pipeline is empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_decays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_rsp
      decay_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_decays.size() == 0) begin
            report_mismatch("response with nothing pending", 64'(rsp_chan.decayed_value), 0);
         end else begin
            want = expected_decays.pop_front();
            if (rsp_chan.decayed_value !== want.decayed_value)
               report_mismatch("decayed_value", 64'(rsp_chan.decayed_value),
                               64'(want.decayed_value));
            if (rsp_chan.vector_done !== want.vector_done)
               report_mismatch("vector_done", 64'(rsp_chan.vector_done), 64'(want.vector_done));
            if (rsp_chan.keep !== want.keep)
               report_mismatch("keep", 64'(rsp_chan.keep), 64'(want.keep));
            if (rsp_chan.too_weak !== want.too_weak)
               report_mismatch("too_weak", 64'(rsp_chan.too_weak), 64'(want.too_weak));
            if (rsp_chan.expired !== want.expired)
               report_mismatch("expired", 64'(rsp_chan.expired), 64'(want.expired));
         end
      end
   end

   task automatic test_default_config();
      send_component(COMP_MAX, 32'd0, 1'b0);
      send_component(COMP_MIN, 32'd0, 1'b0);
      send_component('0, 32'd0, 1'b0);
      send_component(COMP_NEG1, 32'd0, 1'b0);
      send_component(24'd1, 32'd0, 1'b1);
      send_component(COMP_MAX, 32'hFFFF_FFFF, 1'b1);
      send_component(24'h00_1234, 32'd119_999, 1'b1);
   endtask

   task automatic test_decay_limits();
      settle();
      load_config(31'h1FFFF, 31'd0, 31'd0, 31'd1000);
      send_component(COMP_MAX, 32'd0, 1'b0);
      send_component(24'h40_0000, 32'd0, 1'b0);
      send_component(24'd1, 32'd1999, 1'b1);
      settle();
      load_config(31'd0, 31'hFFFF, 31'd1000, 31'd1000);
      send_component(24'h12_3456, 32'd0, 1'b0);
      send_component(COMP_MIN, 32'd2000, 1'b1);
      settle();
      load_config(31'h10000, 31'd0, 31'd1000, 31'd1000);
      send_component(24'h00_ABCD, 32'd0, 1'b0);
      send_component(24'h55_5555, 32'd0, 1'b0);
      send_component('0, 32'd0, 1'b1);
   endtask

   // the norm compare is strict, so an exact tie reports too_weak
   task automatic test_thresholds();
      settle();
      load_config(31'h10000, 31'd0, 31'd2000, 31'h7FFF_FFFF);
      send_component(24'd1000, 32'hFFFF_FFFD, 1'b1);
      settle();
      load_config(31'h10000, 31'd0, 31'd1999, 31'h7FFF_FFFF);
      send_component(24'd1000, 32'hFFFF_FFFE, 1'b1);
      send_component(24'd1000, 32'hFFFF_FFFF, 1'b1);
      settle();
      load_config(31'h10000, 31'd0, 31'd0, 31'd0);
      send_component('0, 32'd0, 1'b1);
      send_component(24'd1, 32'd0, 1'b1);
   endtask

   task automatic test_sum_saturation();
      int i;
      settle();
      load_config(31'h10000, 31'd0, 31'h3FF_FFFF, 31'h7FFF_FFFF);
      for (i = 0; i < 70; i++) send_component(COMP_MAX, 32'd5, i == 69);
      send_component(COMP_MAX, 32'd5, 1'b1);
      send_component(24'd3, 32'd5, 1'b1);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_comp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return {1'b0, (VALUE_BITS-1)'($urandom)};
      if (r < 60) return VALUE_BITS'($urandom);
      if (r < 75) return VALUE_BITS'($urandom_range(1, 1 << FRAC_BITS));
      if (r < 85) return {1'b1, (VALUE_BITS-1)'($urandom)};
      case ($urandom_range(0, 3))
         0: return COMP_MAX;
         1: return COMP_MIN;
         2: return '0;
         default: return COMP_NEG1;
      endcase
   endfunction

   function automatic logic [AGE_W-1:0] random_age();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return AGE_W'($urandom);
      if (r < 60) return AGE_W'($urandom_range(0, 200_000));
      if (r < 85) return AGE_W'(64'(cfg_life) << 1) + AGE_W'($urandom_range(0, 4)) - 2;
      if (r < 92) return '0;
      return '1;
   endfunction

   function automatic int random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 6);
      if (r < 96) return $urandom_range(7, 20);
      return $urandom_range(60, 80);
   endfunction

   task automatic test_random_vectors();
      int phase;
      int sent;
      int len;
      int i;
      logic [DATA_W-1:0] rate, floor, mag, life;
      for (phase = 0; phase < 12; phase++) begin
         settle();
         case (phase)
            0: begin
               rate = 0; floor = 0; mag = 0; life = 0;
            end
            1: begin
               rate = 31'h1FFFF; floor = 31'hFFFF; mag = 31'h3FF_FFFF; life = 31'h7FFF_FFFF;
            end
            2: begin
               rate = 31'h10000; floor = 0; mag = 31'h3FF_FFFF; life = 31'h7FFF_FFFF;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: rate = 0;
                  1: rate = 31'h10000;
                  2: rate = 31'h1FFFF;
                  3: rate = $urandom_range(50_000, 65_536);
                  default: rate = $urandom_range(0, 31'h1FFFF);
               endcase
               case ($urandom_range(0, 3))
                  0: floor = 0;
                  1: floor = 31'hFFFF;
                  2: floor = $urandom_range(1, 16);
                  default: floor = $urandom_range(0, 31'hFFFF);
               endcase
               case ($urandom_range(0, 4))
                  0: mag = 0;
                  1: mag = 31'h3FF_FFFF;
                  2: mag = $urandom_range(0, 1 << 20);
                  3: mag = $urandom_range(0, 1 << 24);
                  default: mag = $urandom_range(0, 31'h3FF_FFFF);
               endcase
               case ($urandom_range(0, 3))
                  0: life = 0;
                  1: life = 31'h7FFF_FFFF;
                  2: life = $urandom_range(0, 100_000);
                  default: life = DATA_W'($urandom);
               endcase
            end
         endcase
         load_config(rate, floor, mag, life);
         gaps_on = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < 100) begin
            len = random_length();
            for (i = 0; i < len; i++) send_component(random_comp(), random_age(), i == len - 1);
            sent += len;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.comp_value = '0;
      req_chan.age_ms = '0;
      req_chan.last_comp = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_decay_limits();
      test_thresholds();
      test_sum_saturation();
      test_random_vectors();
      settle();
      if (error_count == 0) $display("vector_decay_prune: match");
      else $display("vector_decay_prune: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("vector_decay_prune: mismatch");
      $finish;
   end

endmodule

// File: vector_decay_prune.f
src/vdp_pkg.sv
src/vdp_req_if.sv
src/vdp_rsp_if.sv
src/vdp_csr.sv
src/vdp_ctrl.sv
src/vdp_datapath.sv
src/vector_decay_prune.sv
tb/sv/tb.sv
